[src/motor_soft_start_ramp_assert.svh]
// Assertion macros of the soft-start ramp RTL, used by mssr_core.
`ifndef MOTOR_SOFT_START_RAMP_ASSERT_SVH
`define MOTOR_SOFT_START_RAMP_ASSERT_SVH
`ifndef SYNTHESIS
// Check that expr holds at every clock edge out of reset.
`define MSSR_ASSERT_HOLDS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("mssr assertion failed");
// Check that cons holds in the same cycle as ante.
`define MSSR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mssr assertion failed");
// Check that cons holds in the cycle after ante.
`define MSSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mssr assertion failed");
`else
`define MSSR_ASSERT_HOLDS(label, clk, rst_n, expr)
`define MSSR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MSSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/mssr_pkg.sv]
// Package with types, constants and helper functions of the soft-start ramp.
`default_nettype none
package mssr_pkg;

  localparam int PWM_BITS    = 10;
  localparam int LEVEL_BITS  = 16;
  localparam int LVL_W       = LEVEL_BITS + 1;
  localparam int DUTY_W      = PWM_BITS;
  localparam int DUTY_PROD_W = LVL_W + PWM_BITS;
  localparam int OP_W        = 3;
  localparam int ELAPSED_W   = 16;
  localparam int STEP_W      = 17;
  localparam int TL_W        = 17;
  localparam int PROD_W      = ELAPSED_W + STEP_W;

  localparam logic [LVL_W-1:0]  FULL_SCALE = {1'b1, {LEVEL_BITS{1'b0}}};
  localparam logic [LVL_W-1:0]  TARGET_RST = FULL_SCALE >> 2;
  localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(33);

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = OP_W'(0),
    OP_SET_TARGET = OP_W'(1),
    OP_SET_DIR    = OP_W'(2),
    OP_START      = OP_W'(3),
    OP_STOP       = OP_W'(4),
    OP_ESTOP      = OP_W'(5)
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [TL_W-1:0]      target_level;
    logic                 direction_forward;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic              drive_enable;
    logic              direction_pin;
    logic              is_running;
    logic [LVL_W-1:0]  actual_level;
    logic [LVL_W-1:0]  target_now;
  } out_item_t;

  // Event as held in the input register, with the ramp step already scaled.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             tick_live;
    logic [LVL_W-1:0] step;
    logic [TL_W-1:0]  target_level;
    logic             direction_forward;
  } evt_t;

  // Duty = round half up of level * (2^PWM_BITS - 1) / 2^LEVEL_BITS.
  function automatic logic [DUTY_W-1:0] duty_of(input logic [LVL_W-1:0] lv);
    logic [DUTY_PROD_W-1:0] p;
    p = {lv, {PWM_BITS{1'b0}}} - DUTY_PROD_W'(lv) + DUTY_PROD_W'(FULL_SCALE >> 1);
    return p[LEVEL_BITS +: DUTY_W];
  endfunction

endpackage
`default_nettype wire

[src/mssr_in_if.sv]
// Input channel interface of the soft-start ramp.
`default_nettype none
interface mssr_in_if;
  import mssr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/mssr_out_if.sv]
// Result channel interface of the soft-start ramp.
`default_nettype none
interface mssr_out_if;
  import mssr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/mssr_in_stage.sv]
// Input register of the soft-start ramp: ramp_step register and scaled step.
`default_nettype none
module mssr_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [mssr_pkg::STEP_W-1:0] cfg_wdata,
  input  wire mssr_pkg::in_item_t        in_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      take,
  output logic                           evt_valid,
  output mssr_pkg::evt_t                 evt
);
  import mssr_pkg::*;

  logic [STEP_W-1:0] ramp_step_r;
  logic              valid_r;
  logic              valid_nxt;
  evt_t              evt_r;
  evt_t              evt_nxt;
  logic [PROD_W-1:0] prod;
  logic              accept;

  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    prod = PROD_W'(ramp_step_r) * PROD_W'(in_data.elapsed_ms);
    evt_nxt.op                = in_data.operation;
    evt_nxt.tick_live         = (in_data.elapsed_ms != '0);
    evt_nxt.step              = (prod > PROD_W'(FULL_SCALE)) ? FULL_SCALE : LVL_W'(prod);
    evt_nxt.target_level      = in_data.target_level;
    evt_nxt.direction_forward = in_data.direction_forward;
    valid_nxt = accept || (valid_r && !take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r <= STEP_RST;
      valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        ramp_step_r <= cfg_wdata;
      end
      valid_r <= valid_nxt;
    end
    if (accept) begin
      evt_r <= evt_nxt;
    end
  end

  assign evt_valid = valid_r;
  assign evt       = evt_r;
endmodule
`default_nettype wire

[src/mssr_core.sv]
// Ramp state, event decode and result register of the soft-start ramp.
`default_nettype none
`include "motor_soft_start_ramp_assert.svh"
module mssr_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           evt_valid,
  input  wire mssr_pkg::evt_t evt,
  output logic                take,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mssr_pkg::out_item_t out_data
);
  import mssr_pkg::*;

  logic [LVL_W-1:0] level_r, level_nxt;
  logic [LVL_W-1:0] target_r, target_nxt;
  logic             run_r, run_nxt;
  logic             fwd_r, fwd_nxt;
  logic             en_r, en_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic [LVL_W-1:0] dest;
  logic [LVL_W-1:0] diff_up;
  logic [LVL_W-1:0] diff_dn;

  assign take = evt_valid && (!out_valid_r || out_ready);

  always_comb begin
    level_nxt  = level_r;
    target_nxt = target_r;
    run_nxt    = run_r;
    fwd_nxt    = fwd_r;
    en_nxt     = en_r;
    dest       = run_r ? target_r : '0;
    diff_up    = dest - level_r;
    diff_dn    = level_r - dest;
    case (evt.op)
      OP_TICK: begin
        if (evt.tick_live) begin
          if (level_r < dest) begin
            level_nxt = (diff_up <= evt.step) ? dest : level_r + evt.step;
          end else if (level_r > dest) begin
            level_nxt = (diff_dn <= evt.step) ? dest : level_r - evt.step;
          end
          if (!run_r && level_nxt == '0) begin
            en_nxt = 1'b0;
          end
        end
      end
      OP_SET_TARGET: begin
        target_nxt = (evt.target_level > TL_W'(FULL_SCALE)) ? FULL_SCALE
                                                            : LVL_W'(evt.target_level);
      end
      OP_SET_DIR: begin
        if (!run_r && level_r == '0) begin
          fwd_nxt = evt.direction_forward;
        end
      end
      OP_START: begin
        if (target_r != '0) begin
          en_nxt  = 1'b1;
          run_nxt = 1'b1;
        end
      end
      OP_STOP: begin
        run_nxt = 1'b0;
      end
      OP_ESTOP: begin
        run_nxt   = 1'b0;
        level_nxt = '0;
        en_nxt    = 1'b0;
      end
      default: begin
      end
    endcase

    out_nxt.pwm_duty      = duty_of(level_nxt);
    out_nxt.drive_enable  = en_nxt;
    out_nxt.direction_pin = fwd_nxt;
    out_nxt.is_running    = run_nxt;
    out_nxt.actual_level  = level_nxt;
    out_nxt.target_now    = target_nxt;

    out_valid_nxt = take || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      target_r    <= TARGET_RST;
      run_r       <= 1'b0;
      fwd_r       <= 1'b1;
      en_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        level_r  <= level_nxt;
        target_r <= target_nxt;
        run_r    <= run_nxt;
        fwd_r    <= fwd_nxt;
        en_r     <= en_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MSSR_ASSERT_HOLDS(a_level_in_range, clk, rst_n, level_r <= FULL_SCALE)
  `MSSR_ASSERT_HOLDS(a_target_in_range, clk, rst_n, target_r <= FULL_SCALE)
  `MSSR_ASSERT_IMPLIES(a_run_has_enable, clk, rst_n, run_r, en_r)
  `MSSR_ASSERT_NEXT(a_state_holds_idle, clk, rst_n, !take, $stable(level_r) && $stable(en_r))
  `MSSR_ASSERT_NEXT(a_dir_change_safe, clk, rst_n, run_r || level_r != '0, $stable(fwd_r))
endmodule
`default_nettype wire

[src/motor_soft_start_ramp.sv]
// Soft-start motor drive: one event beat in, one drive-status beat out.
// Path: an event is held in the input register, then moves to the result register
//   on the edge that takes it; the result beat is valid from that edge on.
// Throughput: one event per cycle while the sink is ready, set by the update loop.
// Reset (rst_n low, synchronous): level 0, target 25 %, not running, forward,
//   enable low, ramp_step 33, both pipeline registers empty.
`default_nettype none
module motor_soft_start_ramp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [mssr_pkg::STEP_W-1:0]  cfg_wdata,
  mssr_in_if.sink                           in_bus,
  mssr_out_if.source                        out_bus
);
  import mssr_pkg::*;

  // Handshake between the input register and the update/result stage.
  logic evt_valid;
  logic take;
  evt_t evt;

  // Input register: latch the event beat, scale ramp_step by the elapsed time
  // and clamp the step at full scale before the state update sees it.
  mssr_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_bus.data),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .take      (take),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  // Update stage: advance the level toward its destination without overshoot,
  // apply the event, and hold the drive outputs in the result register until
  // the sink takes the beat. The input register refills while a result waits.
  mssr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt       (evt),
    .take      (take),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_data  (out_bus.data)
  );
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the soft-start ramp: directed edges, step extremes, random ramps.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mssr_pkg::*;

  // Opcodes the block has no use for; they must leave the state alone.
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_W'(6);
  localparam logic [OP_W-1:0] OP_SPARE_HI = OP_W'(7);

  localparam longint unsigned PWM_TOP  = (64'd1 << PWM_BITS) - 64'd1;
  localparam longint unsigned DUTY_RND = 64'd1 << (LEVEL_BITS - 1);
  localparam int              PRINT_CAP = 40;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;

  mssr_in_if  in_bus ();
  mssr_out_if out_bus ();

  motor_soft_start_ramp u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  // Shadow of the drive state, advanced once per accepted event beat.
  logic [STEP_W-1:0] shadow_step;
  logic [LVL_W-1:0]  shadow_level;
  logic [LVL_W-1:0]  shadow_target;
  logic              shadow_run;
  logic              shadow_fwd;
  logic              shadow_en;

  out_item_t expected_status[$];
  int        mismatches;
  int        events_sent;
  bit        src_idle_on;
  bit        sink_stall_on;

  // Free-running 125 MHz clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a result beat.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
  endtask

  // Apply one event to the shadow state and return the status beat it must produce.
  function automatic out_item_t advance_drive(input in_item_t ev);
    logic [LVL_W-1:0] dest;
    longint unsigned  move;
    out_item_t        status;
    case (ev.operation)
      OP_TICK: begin
        if (ev.elapsed_ms != '0) begin
          dest = shadow_run ? shadow_target : '0;
          move = longint'(shadow_step) * longint'(ev.elapsed_ms);
          if (move > longint'(FULL_SCALE))
            move = longint'(FULL_SCALE);
          // Step toward the destination, landing on it rather than overshooting.
          if (shadow_level < dest) begin
            if (longint'(dest - shadow_level) <= move)
              shadow_level = dest;
            else
              shadow_level = shadow_level + LVL_W'(move);
          end else if (shadow_level > dest) begin
            if (longint'(shadow_level - dest) <= move)
              shadow_level = dest;
            else
              shadow_level = shadow_level - LVL_W'(move);
          end
          if (!shadow_run && shadow_level == '0)
            shadow_en = 1'b0;
        end
      end
      OP_SET_TARGET: begin
        shadow_target = (ev.target_level > FULL_SCALE) ? FULL_SCALE : ev.target_level;
      end
      OP_SET_DIR: begin
        if (!shadow_run && shadow_level == '0)
          shadow_fwd = ev.direction_forward;
      end
      OP_START: begin
        if (shadow_target != '0) begin
          shadow_en  = 1'b1;
          shadow_run = 1'b1;
        end
      end
      OP_STOP: begin
        shadow_run = 1'b0;
      end
      OP_ESTOP: begin
        shadow_run   = 1'b0;
        shadow_level = '0;
        shadow_en    = 1'b0;
      end
      default: begin
      end
    endcase
    status.pwm_duty      = DUTY_W'((longint'(shadow_level) * PWM_TOP + DUTY_RND) >> LEVEL_BITS);
    status.drive_enable  = shadow_en;
    status.direction_pin = shadow_fwd;
    status.is_running    = shadow_run;
    status.actual_level  = shadow_level;
    status.target_now    = shadow_target;
    return status;
  endfunction

  // Everything observed at the rising edge: reset of the shadow, register writes,
  // result beats checked against the oldest expectation, event beats predicted.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      shadow_step   = STEP_RST;
      shadow_level  = '0;
      shadow_target = TARGET_RST;
      shadow_run    = 1'b0;
      shadow_fwd    = 1'b1;
      shadow_en     = 1'b0;
      expected_status.delete();
    end else begin
      if (cfg_we)
        shadow_step = cfg_wdata;
      if (out_bus.valid && out_bus.ready) begin
        got = out_bus.data;
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected beat, level", got.actual_level, 0);
        end else begin
          want = expected_status.pop_front();
          if (got.pwm_duty !== want.pwm_duty)
            report_mismatch("pwm_duty", got.pwm_duty, want.pwm_duty);
          if (got.drive_enable !== want.drive_enable)
            report_mismatch("drive_enable", got.drive_enable, want.drive_enable);
          if (got.direction_pin !== want.direction_pin)
            report_mismatch("direction_pin", got.direction_pin, want.direction_pin);
          if (got.is_running !== want.is_running)
            report_mismatch("is_running", got.is_running, want.is_running);
          if (got.actual_level !== want.actual_level)
            report_mismatch("actual_level", got.actual_level, want.actual_level);
          if (got.target_now !== want.target_now)
            report_mismatch("target_now", got.target_now, want.target_now);
        end
      end
      if (in_bus.valid && in_bus.ready)
        expected_status.push_back(advance_drive(in_bus.data));
    end
  end

  // Result side: hold ready low in random bursts while stalls are on.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stall_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_bus.ready = 1'b1;
    end
  end

  // Drive one event beat; optionally idle first, then hold valid until the beat is taken.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [ELAPSED_W-1:0] elapsed,
                         input logic [TL_W-1:0] tl, input logic dir);
    in_item_t ev;
    ev.operation         = op;
    ev.elapsed_ms        = elapsed;
    ev.target_level      = tl;
    ev.direction_forward = dir;
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_bus.data  = ev;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    events_sent++;
  endtask

  // Drop valid and wait until every expected status beat is back, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the ramp step register while the block is quiet.
  task automatic load_ramp_step(input logic [STEP_W-1:0] value);
    wait_drained();
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Elapsed time: mostly short ticks so the level passes through many values,
  // sometimes zero, sometimes anything the field holds.
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ELAPSED_W'($urandom);
      2, 3, 4: return ELAPSED_W'($urandom_range(1, 2000));
      default: return ELAPSED_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Target: mostly legal levels, with zero, full scale and over-range values mixed in.
  function automatic logic [TL_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TL_W'($urandom);
      2:       return FULL_SCALE;
      default: return TL_W'($urandom_range(1, 1 << LEVEL_BITS));
    endcase
  endfunction

  task automatic send_tick();
    send_op(OP_TICK, pick_elapsed(), TL_W'($urandom), 1'($urandom));
  endtask

  // One start/run/stop sequence with random content; unused fields carry random bits.
  task automatic ramp_cycle();
    int n;
    if ($urandom_range(0, 2) == 0)
      send_op(OP_SET_DIR, ELAPSED_W'($urandom), TL_W'($urandom), 1'($urandom));
    send_op(OP_SET_TARGET, ELAPSED_W'($urandom), pick_target(), 1'($urandom));
    send_op(OP_START, ELAPSED_W'($urandom), TL_W'($urandom), 1'($urandom));
    n = $urandom_range(2, 12);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0:       send_op(OP_SET_TARGET, ELAPSED_W'($urandom), pick_target(), 1'($urandom));
        1:       send_op(OP_SET_DIR, ELAPSED_W'($urandom), TL_W'($urandom), 1'($urandom));
        default: send_tick();
      endcase
    end
    if ($urandom_range(0, 7) == 0)
      send_op(OP_ESTOP, ELAPSED_W'($urandom), TL_W'($urandom), 1'($urandom));
    else
      send_op(OP_STOP, ELAPSED_W'($urandom), TL_W'($urandom), 1'($urandom));
    // Coast down; sometimes restart or flip direction along the way.
    n = $urandom_range(1, 10);
    repeat (n) begin
      case ($urandom_range(0, 14))
        0:       send_op(OP_START, ELAPSED_W'($urandom), TL_W'($urandom), 1'($urandom));
        1:       send_op(OP_SET_DIR, ELAPSED_W'($urandom), TL_W'($urandom), 1'($urandom));
        default: send_tick();
      endcase
    end
  endtask

  // Any opcode, spare ones included, with fully random fields.
  task automatic noise_event();
    send_op(OP_W'($urandom_range(0, 7)), ELAPSED_W'($urandom), TL_W'($urandom),
            1'($urandom));
  endtask

  // Walk the edges right after reset, with the reset ramp step.
  task automatic test_directed_edges();
    send_op(OP_TICK, 16'h0000, 17'h00000, 1'b1);      // zero elapsed: no change
    send_op(OP_SET_DIR, 16'h0000, 17'h00000, 1'b0);   // stopped at zero: taken
    send_op(OP_SET_DIR, 16'hFFFF, 17'h1FFFF, 1'b1);
    send_op(OP_START, 16'h0000, 17'h00000, 1'b0);     // reset target is nonzero
    send_op(OP_TICK, 16'd100, 17'h00000, 1'b0);
    send_op(OP_SET_DIR, 16'h0000, 17'h00000, 1'b0);   // running: ignored
    send_op(OP_TICK, 16'hFFFF, 17'h00000, 1'b0);      // product saturates, lands on target
    send_op(OP_SET_TARGET, 16'h0000, 17'h1FFFF, 1'b0); // over range: clamp to full
    send_op(OP_TICK, 16'hFFFF, 17'h00000, 1'b0);      // full scale, top duty
    send_op(OP_SET_TARGET, 16'h0000, FULL_SCALE + 1'b1, 1'b1);
    send_op(OP_STOP, 16'h0000, 17'h00000, 1'b0);
    send_op(OP_TICK, 16'd1, 17'h00000, 1'b0);         // level still up: enable holds
    send_op(OP_SET_DIR, 16'h0000, 17'h00000, 1'b0);   // level above zero: ignored
    send_op(OP_TICK, 16'hFFFF, 17'h00000, 1'b0);      // reach zero: enable drops
    send_op(OP_SET_TARGET, 16'hFFFF, 17'h00000, 1'b1);
    send_op(OP_START, 16'h0000, 17'h00000, 1'b1);     // zero target: ignored
    send_op(OP_SPARE_LO, 16'hFFFF, 17'h1FFFF, 1'b1);
    send_op(OP_SPARE_HI, 16'hFFFF, 17'h1FFFF, 1'b0);
    send_op(OP_SET_TARGET, 16'h5555, 17'h0AAAA, 1'b0);
    send_op(OP_START, 16'hAAAA, 17'h15555, 1'b1);
    send_op(OP_TICK, 16'hAAAA, 17'h15555, 1'b1);
    send_op(OP_SET_TARGET, 16'hAAAA, 17'h15555, 1'b1);
    send_op(OP_TICK, 16'h5555, 17'h0AAAA, 1'b0);
    send_op(OP_ESTOP, 16'hFFFF, 17'h1FFFF, 1'b1);     // drop level and enable at once
    send_op(OP_SET_DIR, 16'h0000, 17'h00000, 1'b0);
  endtask

  // Run short ramps at zero, minimum, full-scale and widest ramp steps.
  task automatic test_step_extremes();
    logic [STEP_W-1:0] steps[4];
    steps[0] = '0;
    steps[1] = STEP_W'(1);
    steps[2] = STEP_W'(FULL_SCALE);
    steps[3] = '1;
    foreach (steps[i]) begin
      load_ramp_step(steps[i]);
      repeat (3) ramp_cycle();
    end
  endtask

  // Bulk of the run: mostly well-formed ramps, some noise, new steps now and then.
  task automatic test_random_ramps(input int quota);
    int start_count;
    int next_reload;
    bit paused;
    start_count = events_sent;
    next_reload = events_sent;
    paused      = 1'b0;
    while (events_sent - start_count < quota) begin
      if (events_sent >= next_reload) begin
        // Small steps dominate so ramps take many ticks.
        if ($urandom_range(0, 3) == 0)
          load_ramp_step(STEP_W'($urandom));
        else
          load_ramp_step(STEP_W'($urandom_range(1, 2000)));
        next_reload = events_sent + $urandom_range(80, 200);
      end
      // Hold off once mid-run until every status beat is home.
      if (!paused && events_sent - start_count > quota / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) == 0)
        noise_event();
      else
        ramp_cycle();
    end
  endtask

  // Closing stretch at full rate: no idle cycles on either side.
  task automatic test_back_to_back(input int quota);
    int start_count;
    load_ramp_step(STEP_RST);
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    start_count   = events_sent;
    while (events_sent - start_count < quota)
      ramp_cycle();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    mismatches    = 0;
    events_sent   = 0;
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_step_extremes();
    test_random_ramps(520);
    test_back_to_back(150);

    // Drain, then keep the clock running to show any stray beat.
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
